@@ sv/oriented_box_sdf_query_macros.svh @@
// Assertion macros for the oriented box SDF query RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ORIENTED_BOX_SDF_QUERY_MACROS_SVH
`define ORIENTED_BOX_SDF_QUERY_MACROS_SVH

// same-cycle implication
`define OBSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OBSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/obsq_pkg.sv @@
// Package of the oriented box SDF query: payload types, widths, register codes.
// No dependencies; used by the top level, obsq_isqrt and obsq_div.
package obsq_pkg;

    localparam int RM_W     = 20;
    localparam int D_W      = 33;
    localparam int PROD_W   = RM_W + D_W;
    localparam int BODY_W   = 42;
    localparam int EX_W     = BODY_W + 1;
    localparam int PE_W     = BODY_W;
    localparam int PN_W     = 31;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int MAG_W    = 15;
    localparam int GB_W     = 16;
    localparam int GPROD_W  = RM_W + GB_W;
    localparam int GFRAC_W  = 14;
    localparam int ISQRT_DEPTH = SQ_W / 4;
    localparam int DIV_DEPTH   = (MAG_W + 1) / 2;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_POS_Z   = 3'd2;
    localparam logic [2:0] REG_SIZE_X  = 3'd3;
    localparam logic [2:0] REG_SIZE_Y  = 3'd4;
    localparam logic [2:0] REG_SIZE_Z  = 3'd5;
    localparam logic [2:0] REG_QUAT_WX = 3'd6;
    localparam logic [2:0] REG_QUAT_YZ = 3'd7;

    localparam logic [30:0] SIZE_RESET    = 31'd65536;
    localparam logic [31:0] QUAT_WX_RESET = 32'h4000_0000;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] signed_distance;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic               distance_saturated;
    } result_t;

    typedef struct packed {
        logic        outside;
        logic        sat_big;
        logic [2:0]  face;
        logic [2:0]  sg;
        logic [31:0] dist_in;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

@@ sv/oriented_box_sdf_query.sv @@
// Top level of the oriented box SDF query: config registers, transform, excess,
// square roots, normalization and world-frame gradient. Uses obsq_pkg,
// obsq_delay, obsq_isqrt, obsq_div and the assertion macro header.
//
// Usage:
//   point channel: point_valid / point_stall, payload point (x, y, z, Q16.16).
//   result channel: result_valid / result_stall, payload result (distance,
//   world gradient in Q2.14, saturation flag).
//   cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
//   ready, write only while no query is in flight.
// One point per cycle is sustained while the output is not stalled. The depth
// is set by the two 16-stage square-root units (distance and gradient norm)
// followed by the 8-stage normalizing dividers.
// The pipeline advances as one unit: while result_valid is high and
// result_stall is asserted every stage holds, and point_stall is raised.
// Bubbles travel with cleared valid bits.
// Reset clears the valid bits and loads the register defaults: box at the
// origin, unit size, identity rotation.
`include "oriented_box_sdf_query_macros.svh"

module oriented_box_sdf_query (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  obsq_pkg::point_t   point,
    output logic               result_valid,
    input  logic               result_stall,
    output obsq_pkg::result_t  result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int RM_W    = obsq_pkg::RM_W;
    localparam int D_W     = obsq_pkg::D_W;
    localparam int PROD_W  = obsq_pkg::PROD_W;
    localparam int BODY_W  = obsq_pkg::BODY_W;
    localparam int EX_W    = obsq_pkg::EX_W;
    localparam int PE_W    = obsq_pkg::PE_W;
    localparam int PN_W    = obsq_pkg::PN_W;
    localparam int SQ_W    = obsq_pkg::SQ_W;
    localparam int ROOT_W  = obsq_pkg::ROOT_W;
    localparam int MAG_W   = obsq_pkg::MAG_W;
    localparam int GB_W    = obsq_pkg::GB_W;
    localparam int GPROD_W = obsq_pkg::GPROD_W;
    localparam int GFRAC_W = obsq_pkg::GFRAC_W;
    localparam int NUM_W   = ROOT_W + MAG_W - 1;
    localparam int SIDE_W  = obsq_pkg::SIDE_W;

    localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

    function automatic logic signed [RM_W-1:0] round_q28(input logic signed [35:0] v);
        logic signed [36:0] t;
        t = 37'(v) + (v[35] ? 37'sd8191 : 37'sd8192);
        return t[RM_W+13:14];
    endfunction

    function automatic logic signed [15:0] grad_round(input logic signed [GPROD_W+1:0] v);
        logic signed [GPROD_W+2:0] t;
        logic signed [GPROD_W+2-GFRAC_W:0] r;
        t = (GPROD_W+3)'(v) + (v[GPROD_W+1] ? (GPROD_W+3)'(8191) : (GPROD_W+3)'(8192));
        r = t[GPROD_W+2:GFRAC_W];
        if (r > (GPROD_W+3-GFRAC_W)'(32767))
        begin
            return 16'sh7FFF;
        end
        else if (r < -(GPROD_W+3-GFRAC_W)'(32768))
        begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // ---------------- configuration registers
    logic signed [31:0] pos_reg [3];
    logic [30:0]        size_reg [3];
    logic [31:0]        qwx_reg;
    logic [31:0]        qyz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= '0;
                size_reg[i] <= obsq_pkg::SIZE_RESET;
            end
            qwx_reg <= obsq_pkg::QUAT_WX_RESET;
            qyz_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                obsq_pkg::REG_POS_X:   pos_reg[0]  <= cfg_data;
                obsq_pkg::REG_POS_Y:   pos_reg[1]  <= cfg_data;
                obsq_pkg::REG_POS_Z:   pos_reg[2]  <= cfg_data;
                obsq_pkg::REG_SIZE_X:  size_reg[0] <= cfg_data[30:0];
                obsq_pkg::REG_SIZE_Y:  size_reg[1] <= cfg_data[30:0];
                obsq_pkg::REG_SIZE_Z:  size_reg[2] <= cfg_data[30:0];
                obsq_pkg::REG_QUAT_WX: qwx_reg     <= cfg_data;
                obsq_pkg::REG_QUAT_YZ: qyz_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- rotation matrix, refreshed every cycle
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
    logic signed [35:0] m_raw [3][3];
    logic signed [RM_W-1:0] m_reg [3][3];

    assign qw = signed'(qwx_reg[31:16]);
    assign qx = signed'(qwx_reg[15:0]);
    assign qy = signed'(qyz_reg[31:16]);
    assign qz = signed'(qyz_reg[15:0]);

    always_comb
    begin
        p_xx = qx * qx;
        p_yy = qy * qy;
        p_zz = qz * qz;
        p_xy = qx * qy;
        p_xz = qx * qz;
        p_yz = qy * qz;
        p_wx = qw * qx;
        p_wy = qw * qy;
        p_wz = qw * qz;
        m_raw[0][0] = ONE_Q28 - ((36'(p_yy) + 36'(p_zz)) <<< 1);
        m_raw[0][1] = (36'(p_xy) - 36'(p_wz)) <<< 1;
        m_raw[0][2] = (36'(p_xz) + 36'(p_wy)) <<< 1;
        m_raw[1][0] = (36'(p_xy) + 36'(p_wz)) <<< 1;
        m_raw[1][1] = ONE_Q28 - ((36'(p_xx) + 36'(p_zz)) <<< 1);
        m_raw[1][2] = (36'(p_yz) - 36'(p_wx)) <<< 1;
        m_raw[2][0] = (36'(p_xz) - 36'(p_wy)) <<< 1;
        m_raw[2][1] = (36'(p_yz) + 36'(p_wx)) <<< 1;
        m_raw[2][2] = ONE_Q28 - ((36'(p_xx) + 36'(p_yy)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_reg[i][j] <= round_q28(m_raw[i][j]);
            end
        end
    end

    // ---------------- pipeline control
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v33, v34_reg;

    assign en          = !result_valid || !result_stall;
    assign point_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            v34_reg      <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= point_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            v8_reg       <= v7_reg;
            v34_reg      <= v33;
            result_valid <= v34_reg;
        end
    end

    // ---------------- offset, rotate into box frame, excess
    logic signed [D_W-1:0]    d_reg [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [BODY_W-1:0] body_reg [3];
    logic signed [EX_W-1:0]   ex_reg [3];
    logic [2:0]               sg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= 33'(signed'(point.point_x)) - 33'(pos_reg[0]);
            d_reg[1] <= 33'(signed'(point.point_y)) - 33'(pos_reg[1]);
            d_reg[2] <= 33'(signed'(point.point_z)) - 33'(pos_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= m_reg[j][i] * d_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [PROD_W+1:0] acc;
        logic signed [PROD_W+2:0] t;
        logic [BODY_W-1:0]        mag_b;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = (PROD_W+2)'(prod_reg[i][0]) + (PROD_W+2)'(prod_reg[i][1])
                    + (PROD_W+2)'(prod_reg[i][2]);
                t = (PROD_W+3)'(acc)
                    + (acc[PROD_W+1] ? (PROD_W+3)'(4095) : (PROD_W+3)'(4096));
                body_reg[i] <= t[BODY_W+12:13];
            end
            for (int i = 0; i < 3; i++)
            begin
                mag_b = body_reg[i][BODY_W-1] ? BODY_W'(-body_reg[i]) : body_reg[i];
                ex_reg[i] <= signed'({1'b0, mag_b}) - signed'({(EX_W-31)'(0), size_reg[i]});
                sg_reg[i] <= !body_reg[i][BODY_W-1] && (body_reg[i] != '0);
            end
        end
    end

    // ---------------- max excess, positive excess, face flags
    obsq_pkg::side_t     side_next, side_reg, side_d;
    logic [PE_W-1:0]     pe_reg [3];
    logic signed [EX_W-1:0] mx;

    always_comb
    begin
        logic signed [EX_W:0] t;
        mx = ex_reg[0];
        if (ex_reg[1] > mx)
        begin
            mx = ex_reg[1];
        end
        if (ex_reg[2] > mx)
        begin
            mx = ex_reg[2];
        end
        t = (EX_W+1)'(mx) + (mx[EX_W-1] ? (EX_W+1)'(0) : (EX_W+1)'(1));
        side_next.outside = (mx > 0);
        side_next.sat_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            side_next.face[i] = (ex_reg[i] == mx);
            if ((ex_reg[i] > 0) && (ex_reg[i][EX_W-2:32] != '0))
            begin
                side_next.sat_big = 1'b1;
            end
        end
        side_next.sg      = sg_reg;
        side_next.dist_in = t[32:1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            for (int i = 0; i < 3; i++)
            begin
                pe_reg[i] <= (ex_reg[i] > 0) ? ex_reg[i][PE_W-1:0] : '0;
            end
        end
    end

    // ---------------- squares, gradient normalization shift
    logic [SQ_W-1:0]   ds_reg [3];
    logic [PN_W-1:0]   pn_reg [3];
    logic [3:0]        sh;
    logic [PE_W-1:0]   pe_or;

    always_comb
    begin
        pe_or = pe_reg[0] | pe_reg[1] | pe_reg[2];
        sh    = '0;
        for (int b = PN_W; b < PE_W; b++)
        begin
            if (pe_or[b])
            begin
                sh = 4'(b - PN_W + 1);
            end
        end
    end

    logic [SQ_W-1:0]   dsum7_reg, dsum8_reg, gsum_reg;
    logic [2*PN_W-1:0] gs_reg [3];

    always_ff @(posedge clk)
    begin
        logic [SQ_W+1:0] dsum;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ds_reg[i] <= pe_reg[i][31:0] * pe_reg[i][31:0];
                pn_reg[i] <= PN_W'(pe_reg[i] >> sh);
                gs_reg[i] <= pn_reg[i] * pn_reg[i];
            end
            dsum = (SQ_W+2)'(ds_reg[0]) + (SQ_W+2)'(ds_reg[1]) + (SQ_W+2)'(ds_reg[2]);
            dsum7_reg <= dsum[SQ_W+1:2];
            dsum8_reg <= dsum7_reg;
            gsum_reg  <= SQ_W'(gs_reg[0]) + SQ_W'(gs_reg[1]) + SQ_W'(gs_reg[2]);
        end
    end

    // ---------------- square roots
    logic [ROOT_W-1:0] nd, ng;

    obsq_isqrt #(.RAD_W(SQ_W)) u_isqrt_dist (
        .clk  (clk),
        .en   (en),
        .rad  (dsum8_reg),
        .root (nd)
    );

    obsq_isqrt #(.RAD_W(SQ_W)) u_isqrt_grad (
        .clk  (clk),
        .en   (en),
        .rad  (gsum_reg),
        .root (ng)
    );

    // ---------------- side lines
    logic [3*PN_W-1:0] pn_pack, pn_pack_d;
    logic [ROOT_W:0]   nd_line_d;
    logic [SIDE_W-1:0] side_bits_d;

    assign pn_pack = {pn_reg[2], pn_reg[1], pn_reg[0]};

    obsq_delay #(.W(3 * PN_W), .DEPTH(obsq_pkg::ISQRT_DEPTH + 2)) u_pn_line (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (pn_pack),
        .dout (pn_pack_d)
    );

    obsq_delay #(.W(ROOT_W + 1), .DEPTH(obsq_pkg::DIV_DEPTH + 1)) u_nd_line (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  ({ng != '0, nd}),
        .dout (nd_line_d)
    );

    obsq_delay #(.W(SIDE_W), .DEPTH(obsq_pkg::ISQRT_DEPTH + obsq_pkg::DIV_DEPTH + 4))
        u_side_line (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (side_reg),
        .dout (side_bits_d)
    );

    obsq_delay #(.W(1), .DEPTH(obsq_pkg::ISQRT_DEPTH + obsq_pkg::DIV_DEPTH + 1)) u_valid_line (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (v8_reg),
        .dout (v33)
    );

    assign side_d = side_bits_d;

    // ---------------- normalize: (pn * 2^14 + n/2) / n
    logic [NUM_W-1:0]  num_reg [3];
    logic [ROOT_W-1:0] den_reg;
    logic [MAG_W-1:0]  mag [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= {pn_pack_d[i*PN_W +: PN_W], GFRAC_W'(0)}
                              + NUM_W'(ng >> 1);
            end
            den_reg <= ng;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        obsq_div #(.DEN_W(ROOT_W), .Q_W(MAG_W)) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (mag[i])
        );
    end

    // ---------------- body gradient, rotate back, distance select
    logic signed [GB_W-1:0]    gb [3];
    logic signed [GPROD_W-1:0] gprod_reg [3][3];
    logic signed [31:0]        dist34_reg;
    logic                      sat34_reg;
    logic                      sat_now;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (side_d.outside)
            begin
                if (!nd_line_d[ROOT_W])
                begin
                    gb[j] = '0;
                end
                else if (side_d.sg[j])
                begin
                    gb[j] = signed'({1'b0, mag[j]});
                end
                else
                begin
                    gb[j] = -signed'({1'b0, mag[j]});
                end
            end
            else if (side_d.face[j])
            begin
                gb[j] = side_d.sg[j] ? 16'sd16384 : -16'sd16384;
            end
            else
            begin
                gb[j] = '0;
            end
        end
        sat_now = side_d.outside && (side_d.sat_big || nd_line_d[ROOT_W-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    gprod_reg[i][j] <= m_reg[i][j] * gb[j];
                end
            end
            sat34_reg <= sat_now;
            if (!side_d.outside)
            begin
                dist34_reg <= side_d.dist_in;
            end
            else if (sat_now)
            begin
                dist34_reg <= 32'sh7FFF_FFFF;
            end
            else
            begin
                dist34_reg <= nd_line_d[ROOT_W-1:0];
            end
        end
    end

    // ---------------- output register
    logic signed [GPROD_W+1:0] gacc [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gacc[i] = (GPROD_W+2)'(gprod_reg[i][0]) + (GPROD_W+2)'(gprod_reg[i][1])
                    + (GPROD_W+2)'(gprod_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result.signed_distance    <= dist34_reg;
            result.grad_x             <= grad_round(gacc[0]);
            result.grad_y             <= grad_round(gacc[1]);
            result.grad_z             <= grad_round(gacc[2]);
            result.distance_saturated <= sat34_reg;
        end
    end

    // ---------------- assertions
    `OBSQ_ASSERT_IMP(a_sat_pins_max, result_valid && result.distance_saturated, result.signed_distance == 32'sh7FFFFFFF, "saturated distance not clamped")
    `OBSQ_ASSERT_IMP(a_inside_face, v33 && !side_d.outside, side_d.face != 3'b000, "inside point without nearest face")
    `OBSQ_ASSERT_IMP(a_mag_bound, v33 && side_d.outside, (mag[0] <= 15'd16384) && (mag[1] <= 15'd16384) && (mag[2] <= 15'd16384), "normalized gradient above one")
    `OBSQ_ASSERT_NXT(a_hold_on_stall, point_stall, result_valid && $stable(result), "result moved while pipeline held")

endmodule

@@ sv/obsq_delay.sv @@
// Enabled delay line carrying side data alongside the arithmetic pipeline.
// No package dependencies.
module obsq_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

@@ sv/obsq_isqrt.sv @@
// Pipelined integer square root, two result bits per stage.
// Depends on obsq_pkg for the default radicand width.
module obsq_isqrt #(
    parameter int RAD_W = obsq_pkg::SQ_W
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [RAD_W-1:0]     rad,
    output logic [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STAGES = RAD_W / 4;

    logic [REM_W-1:0]  rem_reg  [STAGES-1];
    logic [RAD_W-1:0]  rad_reg  [STAGES-1];
    logic [ROOT_W-1:0] root_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_next;
        logic [RAD_W-1:0]  rad_in;
        logic [RAD_W-1:0]  rad_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign rad_in  = rad;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] trial;
            rem_next  = rem_in;
            rad_next  = rad_in;
            root_next = root_in;
            trial     = '0;
            for (int t = 0; t < 2; t++)
            begin
                rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                rad_next = {rad_next[RAD_W-3:0], 2'b00};
                trial    = {1'b0, root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= root_next;
            end
        end

        if (s < STAGES - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    rad_reg[s] <= rad_next;
                end
            end
        end
    end

    assign root = root_reg[STAGES-1];

endmodule

@@ sv/obsq_div.sv @@
// Pipelined restoring divider, two quotient bits per stage.
// Depends on obsq_pkg for default widths; quotient must fit in Q_W bits.
module obsq_div #(
    parameter int DEN_W = obsq_pkg::ROOT_W,
    parameter int Q_W   = obsq_pkg::MAG_W
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [DEN_W+Q_W-2:0]   num,
    input  logic [DEN_W-1:0]       den,
    output logic [Q_W-1:0]         quo
);

    localparam int NUM_W  = DEN_W + Q_W - 1;
    localparam int STAGES = (Q_W + 1) / 2;

    logic [NUM_W-1:0] rem_reg [STAGES-1];
    logic [DEN_W-1:0] den_reg [STAGES-1];
    logic [Q_W-1:0]   quo_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int K0 = Q_W - 1 - 2 * s;

        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] rem_next;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [Q_W-1:0]   quo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [NUM_W-1:0] sub;
            rem_next = rem_in;
            quo_next = quo_in;
            sub      = '0;
            for (int t = 0; t < 2; t++)
            begin
                if (K0 - t >= 0)
                begin
                    sub = NUM_W'(den_in) << (K0 - t);
                    if (rem_next >= sub)
                    begin
                        rem_next = rem_next - sub;
                        quo_next = quo_next | (Q_W'(1) << (K0 - t));
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_next;
            end
        end

        if (s < STAGES - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule
